// ----- rtl/gcfem_pkg.sv -----
`default_nettype none
package gcfem_pkg;

	localparam int VERTICES  = 8;
	localparam int EDGE_BITS = 28;
	localparam int PAIRS     = (VERTICES * (VERTICES - 1)) / 2;
	localparam int SET_W     = 8;
	localparam int CNT_W     = 4;
	localparam int ROUNDS    = VERTICES - 1;
	localparam int ROUND_W   = $clog2(VERTICES);

	typedef logic [VERTICES-1:0] vset_t;
	typedef logic [VERTICES-1:0][VERTICES-1:0] adj_t;

	typedef struct packed {
		logic load;
		logic step;
	} reach_ctrl_t;

	typedef struct packed {
		vset_t reached;
		vset_t grown;
	} reach_stat_t;

	// Pair k of the upper triangle sits at mask bit PAIRS-1-k; bits above the
	// mask width read as no edge.
	function automatic adj_t build_adj(input logic [EDGE_BITS-1:0] mask);
		adj_t adj;
		int   pos;
		adj = '0;
		pos = PAIRS;
		for (int r = 0; r < VERTICES; r++) begin
			for (int c = r + 1; c < VERTICES; c++) begin
				pos = pos - 1;
				if (pos < EDGE_BITS) begin
					if (mask[pos]) begin
						adj[r][c] = 1'b1;
						adj[c][r] = 1'b1;
					end
				end
			end
		end
		return adj;
	endfunction

	function automatic logic [CNT_W-1:0] count_set(input vset_t v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < VERTICES; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	function automatic logic [SET_W-1:0] report_set(input vset_t v);
		logic [SET_W-1:0] s;
		s = '0;
		for (int i = 0; i < SET_W; i++) begin
			if (i < VERTICES) begin
				s[i] = v[i];
			end
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/gcfem_reach.sv -----
`default_nettype none
module gcfem_reach (
	input  wire logic                             clk,
	input  wire gcfem_pkg::reach_ctrl_t           ctrl,
	input  wire logic [gcfem_pkg::EDGE_BITS-1:0]  edge_mask,
	output gcfem_pkg::reach_stat_t                stat
);

	gcfem_pkg::adj_t  adj_q;
	gcfem_pkg::vset_t reached_q;
	gcfem_pkg::vset_t grown;

	// One expansion round: merge the adjacency rows of every reached vertex.
	always_comb begin
		grown = reached_q;
		for (int r = 0; r < gcfem_pkg::VERTICES; r++) begin
			if (reached_q[r]) begin
				grown = grown | adj_q[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			adj_q     <= gcfem_pkg::build_adj(edge_mask);
			reached_q <= gcfem_pkg::vset_t'(1);
		end else if (ctrl.step) begin
			reached_q <= grown;
		end
	end

	assign stat.reached = reached_q;
	assign stat.grown   = grown;

endmodule
`default_nettype wire

// ----- rtl/graph_connectivity_from_edge_mask.sv -----
`default_nettype none
// Connectivity check for an undirected graph on gcfem_pkg::VERTICES vertices. Each input
// item is an edge mask over the upper triangle (bit 27 is the pair (0,1), bit 0 the pair
// (6,7)); each item yields exactly one result item with the set of vertices reachable
// from vertex 0, its size and a connected flag. The mask is turned into adjacency rows
// when the item is accepted, and then a single expansion unit merges the rows of all
// reached vertices once per cycle. It stops as soon as a round adds nothing, or after
// VERTICES-1 rounds. An item therefore occupies the block from the accept cycle through
// its growing rounds to a closing cycle in which the result is written to the output
// register. in_stall is high while the item is in the run state, including that closing
// cycle, and low in the accept cycle. The output register lets a new item be accepted
// while the previous result still waits to be taken; a finished search holds until that
// register is free.
module graph_connectivity_from_edge_mask (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [gcfem_pkg::EDGE_BITS-1:0]  edge_mask,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [gcfem_pkg::SET_W-1:0]           reached_set,
	output logic [gcfem_pkg::CNT_W-1:0]           reached_count,
	output logic                                  connected
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	logic [gcfem_pkg::ROUND_W-1:0]   round_q;
	logic                            out_valid_q;
	logic [gcfem_pkg::SET_W-1:0]     reached_set_q;
	logic [gcfem_pkg::CNT_W-1:0]     reached_count_q;
	logic                            connected_q;

	gcfem_pkg::reach_ctrl_t          ctrl;
	gcfem_pkg::reach_stat_t          stat;

	logic                            accept;
	logic                            can_step;
	logic                            finished;
	logic                            slot_free;
	logic                            retire;
	gcfem_pkg::vset_t                result;
	logic [gcfem_pkg::CNT_W-1:0]     result_count;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// No further round is taken once the round budget is used up.
	assign can_step  = (round_q != gcfem_pkg::ROUND_W'(gcfem_pkg::ROUNDS));
	assign result    = can_step ? stat.grown : stat.reached;
	assign finished  = !can_step || (stat.grown == stat.reached);
	assign slot_free = !out_valid_q || !out_stall;
	assign retire    = (state_q == ST_RUN) && finished && slot_free;

	assign result_count = gcfem_pkg::count_set(result);

	always_comb begin
		ctrl.load = accept;
		ctrl.step = (state_q == ST_RUN) && can_step && !retire;
	end

	gcfem_reach u_reach (
		.clk       (clk),
		.ctrl      (ctrl),
		.edge_mask (edge_mask),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					if (retire) begin
						state_q <= ST_IDLE;
					end else if (can_step) begin
						round_q <= round_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result payload is only written when the output register is free.
	always_ff @(posedge clk) begin
		if (retire) begin
			reached_set_q   <= gcfem_pkg::report_set(result);
			reached_count_q <= result_count;
			connected_q     <= (result_count == gcfem_pkg::CNT_W'(gcfem_pkg::VERTICES));
		end
	end

	assign out_valid     = out_valid_q;
	assign reached_set   = reached_set_q;
	assign reached_count = reached_count_q;
	assign connected     = connected_q;

endmodule
`default_nettype wire
